// ===== sv/tscs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the tree search child selector: sizes, lookup tables, divider types.
// No dependencies; used by the divider, the selector and the testbench.
package tscs_pkg;

  localparam int MAX_CHILDREN = 512;
  localparam int LOG_TABLE    = 256;

  localparam int RUN_W  = $clog2(MAX_CHILDREN + 1);
  localparam int POS_W  = 9;
  localparam int TIDX_W = $clog2(LOG_TABLE + 1);
  localparam int J_W    = 16 + TIDX_W;
  localparam int TAB_W  = 18;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  localparam int DIV_REM_W = 24;
  localparam int DIV_DVD_W = 22;
  localparam int DIV_CNT_W = 5;

  typedef logic [TAB_W-1:0] tab_t [0:LOG_TABLE];

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_REM_W-1:0] rem_init;
    logic [DIV_DVD_W-1:0] dvd;
    logic [DIV_REM_W-1:0] dsr;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [DIV_DVD_W-1:0] quo;
  } div_rsp_t;

  // 16-bit fraction of log2(u / 2^16) by repeated squaring
  function automatic longint unsigned lg_frac(longint unsigned u);
    longint unsigned z;
    longint unsigned r;
    int b;
    r = 0;
    if (u >= 64'd131072) return 64'd65536;
    z = u << 14;
    for (b = 15; b >= 0; b--) begin
      z = (z * z) >> 30;
      if (z >= (64'd2 << 30)) begin
        r = r | (64'd1 << b);
        z = z >> 1;
      end
    end
    return r;
  endfunction

  function automatic tab_t build_lg();
    tab_t t;
    longint unsigned x;
    int i;
    for (i = 0; i <= LOG_TABLE; i++) begin
      x = (longint'(i) * 65536) / LOG_TABLE;
      t[i] = TAB_W'(lg_frac(64'd65536 + x));
    end
    return t;
  endfunction

  function automatic tab_t build_ex();
    tab_t t;
    longint unsigned x;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    int i;
    for (i = 0; i <= LOG_TABLE; i++) begin
      x  = (longint'(i) * 65536) / LOG_TABLE;
      lo = 64'd65536;
      hi = 64'd131072;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (lg_frac(mid) >= x) hi = mid;
        else lo = mid + 1;
      end
      t[i] = TAB_W'(lo);
    end
    return t;
  endfunction

  localparam tab_t LG_TAB = build_lg();
  localparam tab_t EX_TAB = build_ex();

endpackage

// ===== sv/tscs_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on tscs_pkg (request and response types).
module tscs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tscs_pkg::div_req_t req,
  output tscs_pkg::div_rsp_t rsp
);

  logic [tscs_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [tscs_pkg::DIV_REM_W-1:0] rem_r, rem_nxt, dsr_r;
  logic [tscs_pkg::DIV_DVD_W-1:0] dvd_r, quo_r;
  logic [tscs_pkg::DIV_REM_W:0]   trial, diff;
  logic                           ge;

  always_comb begin
    trial   = {rem_r, dvd_r[tscs_pkg::DIV_DVD_W-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? diff[tscs_pkg::DIV_REM_W-1:0] : trial[tscs_pkg::DIV_REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= req.steps;
      rem_r <= req.rem_init;
      dvd_r <= req.dvd;
      dsr_r <= req.dsr;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[tscs_pkg::DIV_DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[tscs_pkg::DIV_DVD_W-2:0], ge};
    end
  end

  assign rsp.busy   = cnt_r != '0;
  assign rsp.quo    = quo_r;

endmodule

// ===== sv/tree_search_child_select.sv =====
`timescale 1ns / 1ps
// A request without a child (or past the child limit) is answered from the idle
// state; a child with visits may run the winrate division, an unvisited child skips
// it, and a child with a zero parent count goes from the winrate to the compare. The
// divider takes 17 steps for the winrate; the exponent scaling by 40 is a reciprocal multiply.
// One request at a time; a result stalls new requests until it is taken.
// Reset (rst_n low, synchronous) clears the run and drops any pending result.
module tree_search_child_select (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_color,
  input  logic [23:0] in_parent_visits,
  input  logic [16:0] in_parent_value,
  input  logic        in_present,
  input  logic [16:0] in_child_policy,
  input  logic [23:0] in_child_visits,
  input  logic [39:0] in_child_wins,
  input  logic [9:0]  in_child_move,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [9:0]  out_best_move,
  output logic [8:0]  out_best_position,
  output logic [31:0] out_best_score
);

  localparam logic [4:0] WR_STEPS = 5'd17;
  // ceil(2^26 / 5)
  localparam logic [23:0] E_RCP   = 24'd13421773;

  typedef enum logic [3:0] {
    S_IDLE, S_WSET, S_WDIV, S_LOGN, S_LOGM, S_LOGA, S_EPREP,
    S_EDIV, S_EFIN, S_EXM, S_EXA, S_UCT, S_CMP
  } state_t;

  state_t state_r, state_nxt;

  logic        color_r, color_nxt, last_r, last_nxt;
  logic [23:0] pv_r, pv_nxt, cv_r, cv_nxt;
  logic [16:0] pval_r, pval_nxt, pol_r, pol_nxt, wr_r, wr_nxt;
  logic [39:0] cw_r, cw_nxt;
  logic [9:0]  move_r, move_nxt;
  logic        sel_r, sel_nxt, neg_r, neg_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [15:0] f_r, f_nxt, fr_r, fr_nxt;
  logic [17:0] tlo_r, tlo_nxt;
  logic [20:0] la_r, la_nxt, lb_r, lb_nxt;
  logic [5:0]  sh_r, sh_nxt;
  logic [31:0] score_r, score_nxt;
  logic [35:0] prod_r;
  logic [17:0] mul_a, mul_b;
  logic [26:0] ea_r, ea_nxt;
  logic [21:0] eq_r, eq_nxt;

  logic [31:0] top_score_r, top_score_nxt;
  logic [9:0]  top_move_r, top_move_nxt;
  logic [tscs_pkg::POS_W-1:0] top_pos_r, top_pos_nxt;
  logic        seen_r, seen_nxt;
  logic [tscs_pkg::RUN_W-1:0] run_pos_r, run_pos_nxt;

  logic        out_valid_r, out_valid_nxt, out_found_r, out_found_nxt;
  logic [9:0]  out_move_r, out_move_nxt;
  logic [tscs_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [31:0] out_score_r, out_score_nxt;

  tscs_pkg::div_req_t div_req;
  tscs_pkg::div_rsp_t div_rsp;

  logic        accept, scoring, upd;
  logic [16:0] wr_raw;
  logic [24:0] norm_x, norm_s;
  logic [4:0]  msb;
  logic [15:0] f_in;
  logic [tscs_pkg::J_W-1:0]    j_val;
  logic [tscs_pkg::TIDX_W-1:0] idx, idx1;
  logic [17:0] t_lo, t_hi;
  logic [20:0] lval;
  logic signed [22:0] d2;
  logic signed [27:0] p_val, a_val;
  logic [47:0] eq_prod;
  logic [26:0] eq_x40;
  logic        e_rem_nz;
  logic [22:0] qa, e_val;
  logic signed [7:0]  sh_s;
  logic [17:0] m_val;
  logic [35:0] uct, sum;

  tscs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // shared interpolation path (log table for LOGM, exp table for EXM)
  always_comb begin
    f_in  = (state_r == S_EXM) ? fr_r : f_r;
    j_val = tscs_pkg::J_W'(f_in) * tscs_pkg::J_W'(tscs_pkg::LOG_TABLE);
    idx   = j_val[tscs_pkg::J_W-1:16];
    idx1  = idx + 1'b1;
    t_lo  = (state_r == S_EXM) ? tscs_pkg::EX_TAB[idx]  : tscs_pkg::LG_TAB[idx];
    t_hi  = (state_r == S_EXM) ? tscs_pkg::EX_TAB[idx1] : tscs_pkg::LG_TAB[idx1];
  end

  always_comb begin
    norm_x = sel_r ? (25'(cv_r) + 25'd1) : 25'(pv_r);
    msb    = '0;
    for (int b = 0; b < 25; b++) begin
      if (norm_x[b]) msb = 5'(b);
    end
    norm_s = norm_x << (5'd24 - msb);
  end

  always_comb begin
    lval     = {k_r, 16'b0} + 21'(tlo_r) + 21'(prod_r[35:16]);
    d2       = $signed({2'b0, la_r}) - $signed({1'b0, lb_r, 1'b0});
    p_val    = 28'(d2) * 28'sd23;
    a_val    = p_val[27] ? -p_val : p_val;
    // |p| / 40 as (|p| >> 3) / 5 by reciprocal
    eq_prod  = 48'(ea_r[26:3]) * 48'(E_RCP);
    eq_x40   = {eq_r, 5'b0} + 27'({eq_r, 3'b0});
    e_rem_nz = eq_x40 != ea_r;
    qa       = {1'b0, eq_r} + 23'(neg_r && e_rem_nz);
    e_val    = neg_r ? (~qa + 23'd1) : qa;
    sh_s     = 8'sd16 - 8'(signed'(e_val[22:16]));
    m_val    = tlo_r + 18'(prod_r[35:16]);
    uct      = prod_r >> sh_r;
    sum      = 36'(wr_r) + uct;
  end

  always_comb begin
    state_nxt = state_r;
    color_nxt = color_r;  last_nxt = last_r;  pv_nxt = pv_r;  cv_nxt = cv_r;
    pval_nxt = pval_r;  pol_nxt = pol_r;  cw_nxt = cw_r;  move_nxt = move_r;
    wr_nxt = wr_r;  sel_nxt = sel_r;  neg_nxt = neg_r;  k_nxt = k_r;  f_nxt = f_r;
    fr_nxt = fr_r;  tlo_nxt = tlo_r;  la_nxt = la_r;  lb_nxt = lb_r;  sh_nxt = sh_r;
    ea_nxt = ea_r;  eq_nxt = eq_r;
    score_nxt = score_r;
    top_score_nxt = top_score_r;  top_move_nxt = top_move_r;  top_pos_nxt = top_pos_r;
    seen_nxt = seen_r;  run_pos_nxt = run_pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;  out_move_nxt = out_move_r;
    out_pos_nxt = out_pos_r;  out_score_nxt = out_score_r;
    div_req = '0;
    mul_a = '0;
    mul_b = '0;
    wr_raw = '0;
    upd = 1'b0;
    accept  = in_valid && !in_stall;
    scoring = in_present && (run_pos_r < tscs_pkg::RUN_W'(tscs_pkg::MAX_CHILDREN));

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          color_nxt = in_color;
          last_nxt  = in_last;
          pv_nxt    = in_parent_visits;
          cv_nxt    = in_child_visits;
          cw_nxt    = in_child_wins;
          move_nxt  = in_child_move;
          pval_nxt  = (in_parent_value > tscs_pkg::ONE_Q16) ? tscs_pkg::ONE_Q16
                                                            : in_parent_value;
          pol_nxt   = (in_child_policy > tscs_pkg::ONE_Q16) ? tscs_pkg::ONE_Q16
                                                            : in_child_policy;
          if (scoring) begin
            state_nxt = S_WSET;
          end else if (in_last) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = seen_r;
            out_move_nxt  = top_move_r;
            out_pos_nxt   = top_pos_r;
            out_score_nxt = top_score_r;
            top_score_nxt = '0;
            top_move_nxt  = '0;
            top_pos_nxt   = '0;
            seen_nxt      = 1'b0;
            run_pos_nxt   = '0;
          end
        end
      end
      S_WSET, S_WDIV: begin
        if (state_r == S_WSET && cv_r != '0 && {1'b0, cw_r[39:17]} < cv_r) begin
          div_req.start    = 1'b1;
          div_req.steps    = WR_STEPS;
          div_req.rem_init = {1'b0, cw_r[39:17]};
          div_req.dvd      = {cw_r[16:0], 5'b0};
          div_req.dsr      = cv_r;
          state_nxt        = S_WDIV;
        end else if (state_r == S_WSET || !div_rsp.busy) begin
          priority if (state_r == S_WSET && cv_r == '0) begin
            wr_raw = pval_r;
          end else if (state_r == S_WSET) begin
            wr_raw = tscs_pkg::ONE_Q16;
          end else begin
            wr_raw = (div_rsp.quo[16:0] > tscs_pkg::ONE_Q16) ? tscs_pkg::ONE_Q16
                                                             : div_rsp.quo[16:0];
          end
          wr_nxt = color_r ? (tscs_pkg::ONE_Q16 - wr_raw) : wr_raw;
          if (pv_r == '0) begin
            score_nxt = 32'(wr_nxt);
            state_nxt = S_CMP;
          end else begin
            sel_nxt   = 1'b0;
            state_nxt = S_LOGN;
          end
        end
      end
      S_LOGN: begin
        k_nxt     = msb;
        f_nxt     = norm_s[23:8];
        state_nxt = S_LOGM;
      end
      S_LOGM, S_EXM: begin
        mul_a     = t_hi - t_lo;
        mul_b     = {2'b0, j_val[15:0]};
        tlo_nxt   = t_lo;
        state_nxt = (state_r == S_EXM) ? S_EXA : S_LOGA;
      end
      S_LOGA: begin
        if (!sel_r) begin
          la_nxt    = lval;
          sel_nxt   = 1'b1;
          state_nxt = S_LOGN;
        end else begin
          lb_nxt    = lval;
          state_nxt = S_EPREP;
        end
      end
      S_EPREP: begin
        neg_nxt   = p_val[27];
        ea_nxt    = a_val[26:0];
        state_nxt = S_EDIV;
      end
      S_EDIV: begin
        eq_nxt    = eq_prod[47:26];
        state_nxt = S_EFIN;
      end
      S_EFIN: begin
        fr_nxt    = e_val[15:0];
        sh_nxt    = sh_s[5:0];
        state_nxt = S_EXM;
      end
      S_EXA: begin
        mul_a     = {1'b0, pol_r};
        mul_b     = m_val;
        state_nxt = S_UCT;
      end
      S_UCT: begin
        score_nxt = (sum[35:32] != '0) ? 32'hFFFF_FFFF : sum[31:0];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        upd = !seen_r || (score_r > top_score_r);
        if (upd) begin
          top_score_nxt = score_r;
          top_move_nxt  = move_r;
          top_pos_nxt   = run_pos_r[tscs_pkg::POS_W-1:0];
          seen_nxt      = 1'b1;
        end
        run_pos_nxt = run_pos_r + 1'b1;
        if (last_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_move_nxt  = top_move_nxt;
          out_pos_nxt   = top_pos_nxt;
          out_score_nxt = top_score_nxt;
          top_score_nxt = '0;
          top_move_nxt  = '0;
          top_pos_nxt   = '0;
          seen_nxt      = 1'b0;
          run_pos_nxt   = '0;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_score_r <= '0;
      top_move_r  <= '0;
      top_pos_r   <= '0;
      seen_r      <= 1'b0;
      run_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_score_r <= top_score_nxt;
      top_move_r  <= top_move_nxt;
      top_pos_r   <= top_pos_nxt;
      seen_r      <= seen_nxt;
      run_pos_r   <= run_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    color_r <= color_nxt;  last_r <= last_nxt;  pv_r <= pv_nxt;  cv_r <= cv_nxt;
    pval_r <= pval_nxt;  pol_r <= pol_nxt;  cw_r <= cw_nxt;  move_r <= move_nxt;
    wr_r <= wr_nxt;  sel_r <= sel_nxt;  neg_r <= neg_nxt;  k_r <= k_nxt;  f_r <= f_nxt;
    fr_r <= fr_nxt;  tlo_r <= tlo_nxt;  la_r <= la_nxt;  lb_r <= lb_nxt;  sh_r <= sh_nxt;
    ea_r <= ea_nxt;  eq_r <= eq_nxt;
    score_r <= score_nxt;
    out_found_r <= out_found_nxt;  out_move_r <= out_move_nxt;
    out_pos_r <= out_pos_nxt;  out_score_r <= out_score_nxt;
  end

  assign in_stall          = (state_r != S_IDLE) || out_valid_r;
  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_best_move     = out_move_r;
  assign out_best_position = out_pos_r;
  assign out_best_score    = out_score_r;

endmodule

// ===== sv/tscs_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for tree_search_child_select, attached by bind.
// No package dependency.
module tscs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_present,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [9:0]  out_best_move,
  input logic [8:0]  out_best_position,
  input logic [31:0] out_best_score
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_best_score) &&
    $stable(out_best_move) && $stable(out_found))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_best_score == 32'd0 && out_best_move == 10'd0 &&
    out_best_position == 9'd0)
    else $error("empty run reports nonzero fields");

  a_no_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last |=> !$rose(out_valid))
    else $error("result without final request");

  a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_present && in_last |=> out_valid)
    else $error("final request without child gave no result");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while result pending");

endmodule

bind tree_search_child_select tscs_chk u_tscs_chk (.*);

// ===== dv/tb_tree_search_child_select.sv =====
`timescale 1ns / 1ps
// Testbench for tree_search_child_select: random and directed runs of child requests,
// checked against a scoreboard with its own PUCT score predictor. Depends on tscs_pkg.
module tb_tree_search_child_select;

  typedef struct {
    logic        color;
    logic [23:0] parent_visits;
    logic [16:0] parent_value;
    logic        present;
    logic [16:0] policy;
    logic [23:0] visits;
    logic [39:0] wins;
    logic [9:0]  move;
    logic        last;
  } child_req_t;

  typedef struct {
    logic        found;
    logic [9:0]  move;
    logic [8:0]  position;
    logic [31:0] score;
  } pick_t;

  class child_pick_sb;
    longint unsigned lg_t[0:tscs_pkg::LOG_TABLE];
    longint unsigned ex_t[0:tscs_pkg::LOG_TABLE];
    pick_t picks_due[$];
    logic [31:0] best_score;
    logic [9:0]  best_move;
    logic [8:0]  best_pos;
    bit          any_child;
    int          n_children;
    int          errors;

    function longint unsigned frac_log(longint unsigned u);
      longint unsigned z;
      longint unsigned r;
      int b;
      r = 0;
      if (u >= 131072) return 65536;
      z = u << 14;
      for (b = 15; b >= 0; b--) begin
        z = (z * z) >> 30;
        if (z >= (64'd2 << 30)) begin
          r |= 64'd1 << b;
          z >>= 1;
        end
      end
      return r;
    endfunction

    function new();
      longint unsigned tgt, lo, hi, mid;
      for (int i = 0; i <= tscs_pkg::LOG_TABLE; i++) begin
        tgt = (longint'(i) * 65536) / tscs_pkg::LOG_TABLE;
        lg_t[i] = frac_log(65536 + tgt);
        lo = 65536;
        hi = 131072;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (frac_log(mid) >= tgt) hi = mid;
          else lo = mid + 1;
        end
        ex_t[i] = lo;
      end
      errors = 0;
      clear_run();
    endfunction

    function void clear_run();
      best_score = 0;
      best_move  = 0;
      best_pos   = 0;
      any_child  = 0;
      n_children = 0;
    endfunction

    function longint unsigned lerp(bit use_ex, longint unsigned f);
      longint unsigned j, r, a, b;
      int i;
      j = (f & 64'hFFFF) * tscs_pkg::LOG_TABLE;
      i = int'(j >> 16);
      r = j & 64'hFFFF;
      a = use_ex ? ex_t[i] : lg_t[i];
      b = use_ex ? ex_t[i+1] : lg_t[i+1];
      return a + (((b - a) * r) >> 16);
    endfunction

    function longint log2_fx(longint unsigned x);
      int k;
      longint unsigned u;
      k = 0;
      while (k < 40 && (x >> (k + 1)) != 0) k++;
      u = (k >= 16) ? (x >> (k - 16)) : (x << (16 - k));
      return longint'(k) * 65536 + longint'(lerp(0, u - 65536));
    endfunction

    function logic [31:0] puct(child_req_t c);
      longint unsigned pval, pol, wr, uct, m, ue, s;
      longint d2, p, e;
      int ip, sh;
      pval = (c.parent_value > tscs_pkg::ONE_Q16) ? 65536 : c.parent_value;
      pol  = (c.policy > tscs_pkg::ONE_Q16) ? 65536 : c.policy;
      if (c.visits == 0) wr = pval;
      else begin
        wr = longint'(c.wins) / longint'(c.visits);
        if (wr > 65536) wr = 65536;
      end
      if (c.color) wr = 65536 - wr;
      uct = 0;
      if (c.parent_visits != 0) begin
        d2 = log2_fx(c.parent_visits) - 2 * log2_fx(64'(c.visits) + 1);
        p = d2 * 23;
        if (p >= 0) e = p / 40;
        else e = -((-p + 39) / 40);
        ue = longint'(e + (longint'(64) << 16));
        ip = int'(ue >> 16) - 64;
        m = lerp(1, ue & 64'hFFFF);
        sh = 16 - ip;
        if (sh < 0) sh = 0;
        uct = (sh >= 63) ? 0 : ((pol * m) >> sh);
      end
      s = wr + uct;
      if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
      return s[31:0];
    endfunction

    function void note_request(child_req_t c);
      logic [31:0] s;
      pick_t pk;
      if (c.present && n_children < tscs_pkg::MAX_CHILDREN) begin
        s = puct(c);
        if (!any_child || s > best_score) begin
          best_score = s;
          best_move  = c.move;
          best_pos   = n_children[8:0];
          any_child  = 1;
        end
        n_children++;
      end
      if (c.last) begin
        pk.found    = any_child;
        pk.move     = best_move;
        pk.position = best_pos;
        pk.score    = best_score;
        picks_due.push_back(pk);
        clear_run();
      end
    endfunction

    function void check_result(pick_t got);
      pick_t exp_pk;
      if (picks_due.size() == 0) begin
        $display("%0t: unexpected result found=%0d move=%0d", $time, got.found, got.move);
        errors++;
        return;
      end
      exp_pk = picks_due.pop_front();
      if (got.found !== exp_pk.found) begin
        $display("%0t: found exp %0d got %0d", $time, exp_pk.found, got.found);
        errors++;
      end
      if (got.move !== exp_pk.move) begin
        $display("%0t: best_move exp %0d got %0d", $time, exp_pk.move, got.move);
        errors++;
      end
      if (got.position !== exp_pk.position) begin
        $display("%0t: best_position exp %0d got %0d", $time, exp_pk.position, got.position);
        errors++;
      end
      if (got.score !== exp_pk.score) begin
        $display("%0t: best_score exp %h got %h", $time, exp_pk.score, got.score);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_stall;
  logic        in_color, in_present, in_last;
  logic [23:0] in_parent_visits, in_child_visits;
  logic [16:0] in_parent_value, in_child_policy;
  logic [39:0] in_child_wins;
  logic [9:0]  in_child_move;
  logic        out_valid, out_stall, out_found;
  logic [9:0]  out_best_move;
  logic [8:0]  out_best_position;
  logic [31:0] out_best_score;

  child_pick_sb sb;
  int  idle_cycles;
  int  sent;
  bit  long_hold;
  bit  no_gaps;

  tree_search_child_select u_dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    in_valid = 0; in_color = 0; in_parent_visits = 0; in_parent_value = 0;
    in_present = 0; in_child_policy = 0; in_child_visits = 0; in_child_wins = 0;
    in_child_move = 0; in_last = 0; out_stall = 0; rst_n = 0;
    long_hold = 0;
    no_gaps = 0;
    sb = new();
  end

  always @(posedge clk) begin
    pick_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.found    = out_found;
      got.move     = out_best_move;
      got.position = out_best_position;
      got.score    = out_best_score;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 3000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall per result, with a long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1;
        for (n = 0; n < 600; n++) @(posedge clk);
        long_hold = 0;
      end else begin
        n = no_gaps ? 0 : $urandom_range(13);
        if (n > 0) begin
          out_stall <= 1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 0;
      @(posedge clk);
      while (!(out_valid && !out_stall) && !long_hold) @(posedge clk);
    end
  end

  task automatic send_req(input child_req_t c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(13);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1;
    in_color         <= c.color;
    in_parent_visits <= c.parent_visits;
    in_parent_value  <= c.parent_value;
    in_present       <= c.present;
    in_child_policy  <= c.policy;
    in_child_visits  <= c.visits;
    in_child_wins    <= c.wins;
    in_child_move    <= c.move;
    in_last          <= c.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(c);
    sent++;
  endtask

  function automatic child_req_t rand_child(child_req_t base);
    child_req_t c;
    longint unsigned w;
    c = base;
    c.present = 1;
    c.last = 0;
    c.move = 10'($urandom);
    case ($urandom_range(3))
      0: c.visits = 0;
      1: c.visits = 24'($urandom_range(50));
      2: c.visits = 24'($urandom_range(100000));
      default: c.visits = 24'($urandom);
    endcase
    if ($urandom_range(4) == 0) c.wins = {8'($urandom), 32'($urandom)};
    else begin
      w = longint'(c.visits) * $urandom_range(70000);
      c.wins = w[39:0];
    end
    c.policy = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
    return c;
  endfunction

  task automatic send_run(input int n_kids);
    child_req_t base, c;
    base.color = 1'($urandom);
    case ($urandom_range(4))
      0: base.parent_visits = 0;
      1: base.parent_visits = 24'($urandom_range(200));
      default: base.parent_visits = 24'($urandom);
    endcase
    base.parent_value = ($urandom_range(7) == 0) ? 17'($urandom) :
                        17'($urandom_range(65536));
    for (int k = 0; k < n_kids; k++) begin
      if ($urandom_range(9) == 0) begin
        c = rand_child(base);
        c.present = 0;
        send_req(c);
      end
      c = rand_child(base);
      c.last = (k == n_kids - 1);
      send_req(c);
    end
    if (n_kids == 0) begin
      c = rand_child(base);
      c.present = 0;
      c.last = 1;
      send_req(c);
    end
  endtask

  initial begin
    child_req_t c;
    int n;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, both colors, ties, child-less requests, empty run
    c.color = 0; c.parent_visits = 0; c.parent_value = 17'h1FFFF; c.present = 1;
    c.policy = 17'h1FFFF; c.visits = 0; c.wins = 0; c.move = 10'h3FF; c.last = 0;
    send_req(c);
    c.parent_visits = 24'hFFFFFF; c.visits = 24'hFFFFFF; c.wins = 40'hFF_FFFF_FFFF;
    c.move = 0; send_req(c);
    c.visits = 0; c.policy = 65536; c.move = 5; send_req(c);
    c.present = 0; c.move = 7; send_req(c);
    c.present = 1; c.visits = 1; c.wins = 0; c.policy = 0; c.last = 1; send_req(c);
    c.color = 1; c.parent_visits = 1; c.parent_value = 0; c.visits = 0; c.wins = 0;
    c.policy = 30000; c.move = 11; c.last = 0; send_req(c);
    c.move = 12; send_req(c);
    c.move = 13; c.last = 1; send_req(c);
    c.present = 0; c.last = 1; send_req(c);
    c.present = 0; c.last = 0; send_req(c);
    c.last = 1; send_req(c);
    c.present = 1; c.color = 0; c.parent_visits = 24'hFFFFFF; c.visits = 0;
    c.policy = 65536; c.parent_value = 65536; c.move = 99; send_req(c);
    c.color = 1; c.visits = 24'hFFFFFF; c.wins = 40'hFF_FFFF_FFFF; c.policy = 17'h10001;
    send_req(c);

    while (sent < 1550) begin
      no_gaps = ($urandom_range(4) == 0);
      n = $urandom_range(8) == 0 ? 0 : $urandom_range(1, 8);
      if (sent > 300 && sent < 330) begin
        long_hold = 1;
        send_run(12);
      end else if (sent > 600 && sent < 640) begin
        no_gaps = 1;
        send_run(tscs_pkg::MAX_CHILDREN + 3);
      end else begin
        send_run(n);
      end
      if ($urandom_range(20) == 0) begin
        in_valid <= 0;
        @(posedge clk);
        while (sb.picks_due.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 0;
    @(posedge clk);
    while (sb.picks_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
